@@ rtl/core/pb2a_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pb2a_pkg: shared types and constants of the pixel block to ascii char block
// item formats, register indexes, back end states and the 70-level ramp
// ----------------------------------------------------------------------------
package pb2a_pkg;

    // parameter defaults
    localparam int MAX_COLUMNS_DEF     = 256;
    localparam int MAX_IMAGE_WIDTH_DEF = 4096;
    localparam int CHAR_LEVELS_DEF     = 70;

    // register widths
    localparam int IMG_W      = 13;
    localparam int BLK_W      = 7;
    localparam int COLS_W     = 9;
    localparam int CFG_DATA_W = 13;

    // register reset values
    localparam logic [IMG_W-1:0]  IMG_WIDTH_RST  = 13'd640;
    localparam logic [BLK_W-1:0]  BLK_WIDTH_RST  = 7'd8;
    localparam logic [BLK_W-1:0]  BLK_HEIGHT_RST = 7'd16;
    localparam logic [COLS_W-1:0] OUT_COLS_RST   = 9'd80;

    localparam int BLOCK_MAX = 64;

    // accumulation and division
    localparam int SUM_W = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam int DIV_W = 20;
    localparam int FULL_SCALE_SHIFT = 8;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    // floor(x / 3) for x up to 765 as (x * 683) >> 11
    localparam int GRAY_RECIP = 683;
    localparam int GRAY_SHIFT = 11;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // ramp
    localparam int RAMP_SIZE = 70;
    localparam int QUO_W     = 7;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH,
        CFG_BLOCK_WIDTH,
        CFG_BLOCK_HEIGHT,
        CFG_OUT_COLUMNS
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_row;
    } char_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             end_of_row;
    } cell_t;

    typedef struct packed {
        logic empty;
        logic nearly_full;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // darkest to brightest
    localparam logic [7:0] RAMP [RAMP_SIZE] = '{
        8'h20, 8'h2E, 8'h27, 8'h60, 8'h5E, 8'h22, 8'h2C, 8'h3A, 8'h3B, 8'h49,
        8'h6C, 8'h21, 8'h69, 8'h3E, 8'h3C, 8'h7E, 8'h2B, 8'h5F, 8'h2D, 8'h3F,
        8'h5D, 8'h5B, 8'h7D, 8'h7B, 8'h31, 8'h29, 8'h28, 8'h7C, 8'h5C, 8'h2F,
        8'h74, 8'h66, 8'h6A, 8'h72, 8'h78, 8'h6E, 8'h75, 8'h76, 8'h63, 8'h7A,
        8'h58, 8'h59, 8'h55, 8'h4A, 8'h43, 8'h4C, 8'h51, 8'h30, 8'h4F, 8'h5A,
        8'h6D, 8'h77, 8'h71, 8'h70, 8'h64, 8'h62, 8'h6B, 8'h68, 8'h61, 8'h6F,
        8'h2A, 8'h23, 8'h4D, 8'h57, 8'h26, 8'h38, 8'h25, 8'h42, 8'h40, 8'h24
    };

endpackage
`default_nettype wire

@@ rtl/core/pb2a_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pb2a_ram: generic simple dual port ram
// one write port, one read port with registered read data (read before write)
// ----------------------------------------------------------------------------
module pb2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/core/pb2a_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pb2a_queue: short fifo of finished cell sums
// decouples the pixel front end from the divider back end
// ----------------------------------------------------------------------------
module pb2a_queue
    import pb2a_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  cell_t         push_data,
    input  wire logic     pop,
    output cell_t         pop_data,
    output queue_status_t status
);

    cell_t               slots [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    assign pop_data           = slots[rd_ptr_reg];
    assign status.empty       = (count_reg == '0);
    // one slot is kept for the item still in the front end's second stage
    assign status.nearly_full = (count_reg >= Q_CNT_W'(Q_DEPTH - 1));

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg < Q_CNT_W'(Q_DEPTH)))
        else $error("cell queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0 || $past(push)))
        else $error("cell queue popped while empty");

endmodule
`default_nettype wire

@@ rtl/core/pb2a_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pb2a_front: pixel front end
// gray conversion, raster position counters and per-column cell sums
// ----------------------------------------------------------------------------
module pb2a_front
    import pb2a_pkg::*;
#(
    parameter int MAX_COLUMNS     = MAX_COLUMNS_DEF,
    parameter int MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF,
    localparam int WW  = $clog2(MAX_IMAGE_WIDTH + 1),
    localparam int BCW = $clog2(MAX_COLUMNS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pix_valid,
    output logic                  pix_stall,
    input  pixel_t                pix_data,
    input  wire logic [WW-1:0]    width_eff,
    input  wire logic [BLK_W-1:0] bw_eff,
    input  wire logic [BLK_W-1:0] bh_eff,
    input  wire logic [BCW-1:0]   nc_eff,
    output logic                  q_push,
    output cell_t                 q_push_data,
    input  queue_status_t         q_status
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int XW = $clog2(MAX_IMAGE_WIDTH);
    localparam int PW = BCW + BLK_W + 1;
    localparam int KW = ((PW > WW) ? PW : WW) + 1;
    localparam int IW = 6;

    // position counters
    logic [XW-1:0]  px_reg, px_next;
    logic [IW-1:0]  xib_reg, xib_next;
    logic [IW-1:0]  lib_reg, lib_next;
    logic [BCW-1:0] bc_reg, bc_next;

    // second stage
    logic             s1_valid_reg;
    logic             s1_active_reg;
    logic             s1_emit_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [7:0]       s1_gray_reg;
    logic             s1_load_reg;
    logic             s1_eor_reg;
    logic             s1_hit_reg;
    logic             s1_seen_reg;
    logic [SUM_W-1:0] fwd_reg;

    logic [MAX_COLUMNS-1:0] seen_reg;

    logic             accept;
    logic [XW-1:0]    px;
    logic [IW-1:0]    xib;
    logic [IW-1:0]    lib;
    logic [BCW-1:0]   bc;
    logic [9:0]       rgb;
    logic [19:0]      gray_prod;
    logic [7:0]       gray;
    logic [PW-1:0]    p1;
    logic [PW-1:0]    p2;
    logic             active;
    logic             x_last;
    logic             y_last;
    logic             col_last;
    logic             load;
    logic             hit_now;
    logic             seen_rd;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [SUM_W-1:0] ram_rdata;
    logic [SUM_W-1:0] base;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum;

    assign pix_stall = q_status.nearly_full;
    assign accept    = pix_valid && !pix_stall;

    // ---- first stage: classify the pixel ----
    always_comb
    begin
        px  = pix_data.frame_start ? '0 : px_reg;
        xib = pix_data.frame_start ? '0 : xib_reg;
        lib = pix_data.frame_start ? '0 : lib_reg;
        bc  = pix_data.frame_start ? '0 : bc_reg;

        rgb       = 10'(pix_data.red) + 10'(pix_data.green) + 10'(pix_data.blue);
        gray_prod = 20'(rgb) * 20'(GRAY_RECIP);
        gray      = (pix_data.alpha == ALPHA_OPAQUE) ? gray_prod[GRAY_SHIFT +: 8] : 8'd0;

        // right edge of this cell column and of the next one
        p1 = (PW'(bc) + PW'(1)) * PW'(bw_eff);
        p2 = p1 + PW'(bw_eff);

        active   = (bc < nc_eff) && (KW'(p1) <= KW'(width_eff))
                   && (KW'(px) < KW'(width_eff));
        col_last = ((BCW + 1)'(bc) + (BCW + 1)'(1) == (BCW + 1)'(nc_eff))
                   || (KW'(p2) > KW'(width_eff));
        x_last   = (BLK_W'(xib) == bw_eff - BLK_W'(1));
        y_last   = (BLK_W'(lib) == bh_eff - BLK_W'(1));
        load     = (xib == '0) && (lib == '0);

        // advance
        px_next  = px;
        xib_next = xib;
        lib_next = lib;
        bc_next  = bc;
        if (KW'(px) + KW'(1) >= KW'(width_eff))
        begin
            px_next  = '0;
            xib_next = '0;
            bc_next  = '0;
            lib_next = (BLK_W'(lib) + BLK_W'(1) >= bh_eff) ? '0 : lib + IW'(1);
        end
        else
        begin
            px_next = px + XW'(1);
            if (BLK_W'(xib) + BLK_W'(1) >= bw_eff)
            begin
                xib_next = '0;
                if (bc < BCW'(MAX_COLUMNS))
                begin
                    bc_next = bc + BCW'(1);
                end
            end
            else
            begin
                xib_next = xib + IW'(1);
            end
        end
    end

    assign ram_raddr = bc[AW-1:0];
    assign seen_rd   = (bc < BCW'(MAX_COLUMNS)) ? seen_reg[ram_raddr] : 1'b0;
    // the item in the second stage writes this column at the same edge
    assign hit_now   = ram_we && (ram_waddr == ram_raddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg        <= '0;
            xib_reg       <= '0;
            lib_reg       <= '0;
            bc_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s1_active_reg <= 1'b0;
            s1_emit_reg   <= 1'b0;
            seen_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                px_reg        <= px_next;
                xib_reg       <= xib_next;
                lib_reg       <= lib_next;
                bc_reg        <= bc_next;
                s1_active_reg <= active;
                s1_emit_reg   <= active && x_last && y_last;
            end
            if (ram_we)
            begin
                seen_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg <= sum;
        if (accept)
        begin
            s1_addr_reg <= ram_raddr;
            s1_gray_reg <= gray;
            s1_load_reg <= load;
            s1_eor_reg  <= col_last;
            s1_hit_reg  <= hit_now;
            s1_seen_reg <= seen_rd;
        end
    end

    pb2a_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLUMNS)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sum),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---- second stage: accumulate ----
    always_comb
    begin
        if (s1_load_reg)
        begin
            base = '0;
        end
        else if (s1_hit_reg)
        begin
            base = fwd_reg;
        end
        else if (s1_seen_reg)
        begin
            base = ram_rdata;
        end
        else
        begin
            base = '0;
        end
        sum_wide = {1'b0, base} + (SUM_W + 1)'(s1_gray_reg);
        sum      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    assign ram_we    = s1_valid_reg && s1_active_reg;
    assign ram_waddr = s1_addr_reg;

    assign q_push                 = s1_valid_reg && s1_emit_reg;
    assign q_push_data.sum        = sum;
    assign q_push_data.end_of_row = s1_eor_reg;

    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_hit_reg) |-> $past(ram_we && (ram_waddr == ram_raddr)))
        else $error("forwarded sum without a matching write");

    a_push_writes: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> ram_we)
        else $error("cell emitted without accumulating its column");

endmodule
`default_nettype wire

@@ rtl/core/pb2a_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pb2a_back: divider back end
// scales a cell sum to a ramp level by restoring division and drives the output
// ----------------------------------------------------------------------------
module pb2a_back
    import pb2a_pkg::*;
#(
    parameter int CHAR_LEVELS = CHAR_LEVELS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  queue_status_t         q_status,
    output logic                  q_pop,
    input  cell_t                 q_pop_data,
    input  wire logic [BLK_W-1:0] bw_eff,
    input  wire logic [BLK_W-1:0] bh_eff,
    output logic                  char_valid,
    input  wire logic             char_stall,
    output char_t                 char_data
);

    localparam int LW  = $clog2(CHAR_LEVELS + 1);
    localparam int NW  = SUM_W + LW;
    localparam int DSW = DIV_W + QUO_W;
    localparam int EW  = ((NW > DSW) ? NW : DSW) + 1;
    localparam int CL  = ((CHAR_LEVELS < RAMP_SIZE) ? CHAR_LEVELS : RAMP_SIZE) - 1;
    localparam int SW  = $clog2(QUO_W);

    back_state_t      state_reg, state_next;
    logic [SUM_W-1:0] cell_sum_reg, cell_sum_next;
    logic             eor_reg, eor_next;
    logic [EW-1:0]    rem_reg, rem_next;
    logic [EW-1:0]    dsh_reg, dsh_next;
    logic [SW-1:0]    step_reg, step_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic             ovf_reg, ovf_next;
    logic             out_valid_reg, out_valid_next;
    char_t            out_data_reg, out_data_next;
    logic [DIV_W-1:0] div_reg;

    logic [13:0]      area;
    logic [QUO_W-1:0] idx;

    // cell area, and 255 * cell area in div_reg, refreshed every cycle from the settled registers
    assign area = 14'(bw_eff) * 14'(bh_eff);

    always_ff @(posedge clk)
    begin
        div_reg <= (DIV_W'(area) << FULL_SCALE_SHIFT) - DIV_W'(area);
    end

    assign idx = (ovf_reg || (quo_reg > QUO_W'(CL))) ? QUO_W'(CL) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_sum_reg <= cell_sum_next;
        eor_reg      <= eor_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        step_reg     <= step_next;
        quo_reg      <= quo_next;
        ovf_reg      <= ovf_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cell_sum_next  = cell_sum_reg;
        eor_next       = eor_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        step_next      = step_reg;
        quo_next       = quo_reg;
        ovf_next       = ovf_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && char_stall;
        q_pop          = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop         = 1'b1;
                    cell_sum_next = q_pop_data.sum;
                    eor_next      = q_pop_data.end_of_row;
                    state_next    = BK_MUL;
                end
            end
            BK_MUL:
            begin
                rem_next   = EW'(NW'(cell_sum_reg) * NW'(CHAR_LEVELS));
                dsh_next   = EW'(div_reg) << (QUO_W - 1);
                step_next  = SW'(QUO_W - 1);
                quo_next   = '0;
                ovf_next   = 1'b0;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                // quotient beyond the quotient width saturates to the top level
                if (step_reg == SW'(QUO_W - 1))
                begin
                    ovf_next = (rem_reg >= (dsh_reg << 1));
                end
                if (rem_reg >= dsh_reg)
                begin
                    rem_next           = rem_reg - dsh_reg;
                    quo_next[step_reg] = 1'b1;
                end
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    step_next = step_reg - SW'(1);
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || !char_stall)
                begin
                    out_data_next.char_code  = RAMP[idx];
                    out_data_next.end_of_row = eor_reg;
                    out_valid_next           = 1'b1;
                    state_next               = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign char_valid = out_valid_reg;
    assign char_data  = out_data_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == BK_DONE))
        else $error("character shown without a finished division");

endmodule
`default_nettype wire

@@ rtl/core/pixel_block_to_ascii_char_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_block_to_ascii_char_top: rgba pixel stream to ascii-art characters
//
// pixels enter in raster order on the pix channel (pix_valid / pix_stall),
// one per cycle while pix_stall is low; frame_start restarts the position.
// each pixel's gray is summed into a per-column cell accumulator; the last
// pixel of a complete cell produces one item on the char channel carrying a
// code from the 70-level ramp and an end-of-row flag for the last cell.
// the front end takes one pixel per cycle while not stalled; every character
// passes through the shared restoring divider in turn (one pop, one multiply,
// seven quotient bits, one output load). cells finish one per cell width
// along the last line of a cell row, so cells ten or more pixels wide stream
// at one pixel per cycle; narrower cells fill the 4-entry cell queue, and
// pix_stall rises once three entries are held, until the divider catches up.
// char_valid and char_data hold while char_stall is high; the divider
// finishes the cell in progress and waits, and the queue absorbs the front
// end until it fills.
// reset clears the position counters, queue, divider and output, and loads
// the register defaults (640 wide, 8 x 16 cells, 80 columns); accumulators
// read as zero until first written. the user writes registers through cfg_write
// only while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pixel_block_to_ascii_char_top
    import pb2a_pkg::*;
#(
    parameter int MAX_COLUMNS     = MAX_COLUMNS_DEF,
    parameter int MAX_IMAGE_WIDTH = MAX_IMAGE_WIDTH_DEF,
    parameter int CHAR_LEVELS     = CHAR_LEVELS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // pixel items
    input  wire logic                  pix_valid,
    output logic                       pix_stall,
    input  pixel_t                     pix_data,
    // character items
    output logic                       char_valid,
    input  wire logic                  char_stall,
    output char_t                      char_data,
    // register writes
    input  wire logic                  cfg_write,
    input  cfg_index_t                 cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WW  = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int CW  = ((WW > IMG_W) ? WW : IMG_W) + 1;
    localparam int BCW = $clog2(MAX_COLUMNS + 1);
    localparam int NW  = ((BCW > COLS_W) ? BCW : COLS_W) + 1;

    // configuration registers
    logic [IMG_W-1:0]  img_width_reg;
    logic [BLK_W-1:0]  blk_width_reg;
    logic [BLK_W-1:0]  blk_height_reg;
    logic [COLS_W-1:0] out_cols_reg;

    // settled values: zero acts as one, large values saturate
    logic [WW-1:0]    width_eff;
    logic [BLK_W-1:0] bw_eff;
    logic [BLK_W-1:0] bh_eff;
    logic [BCW-1:0]   nc_eff;

    cell_t         q_push_data;
    cell_t         q_pop_data;
    logic          q_push;
    logic          q_pop;
    queue_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= IMG_WIDTH_RST;
            blk_width_reg  <= BLK_WIDTH_RST;
            blk_height_reg <= BLK_HEIGHT_RST;
            out_cols_reg   <= OUT_COLS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  img_width_reg  <= cfg_data[IMG_W-1:0];
                CFG_BLOCK_WIDTH:  blk_width_reg  <= cfg_data[BLK_W-1:0];
                CFG_BLOCK_HEIGHT: blk_height_reg <= cfg_data[BLK_W-1:0];
                CFG_OUT_COLUMNS:  out_cols_reg   <= cfg_data[COLS_W-1:0];
                default:          img_width_reg  <= img_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (img_width_reg == '0)
        begin
            width_eff = WW'(1);
        end
        else if (CW'(img_width_reg) > CW'(MAX_IMAGE_WIDTH))
        begin
            width_eff = WW'(MAX_IMAGE_WIDTH);
        end
        else
        begin
            width_eff = WW'(img_width_reg);
        end

        if (blk_width_reg == '0)
        begin
            bw_eff = BLK_W'(1);
        end
        else if (blk_width_reg > BLK_W'(BLOCK_MAX))
        begin
            bw_eff = BLK_W'(BLOCK_MAX);
        end
        else
        begin
            bw_eff = blk_width_reg;
        end

        if (blk_height_reg == '0)
        begin
            bh_eff = BLK_W'(1);
        end
        else if (blk_height_reg > BLK_W'(BLOCK_MAX))
        begin
            bh_eff = BLK_W'(BLOCK_MAX);
        end
        else
        begin
            bh_eff = blk_height_reg;
        end

        if (out_cols_reg == '0)
        begin
            nc_eff = BCW'(1);
        end
        else if (NW'(out_cols_reg) > NW'(MAX_COLUMNS))
        begin
            nc_eff = BCW'(MAX_COLUMNS);
        end
        else
        begin
            nc_eff = BCW'(out_cols_reg);
        end
    end

    // front end: gray, counters, column accumulators
    pb2a_front #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix_data    (pix_data),
        .width_eff   (width_eff),
        .bw_eff      (bw_eff),
        .bh_eff      (bh_eff),
        .nc_eff      (nc_eff),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_status    (q_status)
    );

    // finished cell sums waiting for the divider
    pb2a_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // back end: level division, ramp lookup, output register
    pb2a_back #(
        .CHAR_LEVELS (CHAR_LEVELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .q_pop_data (q_pop_data),
        .bw_eff     (bw_eff),
        .bh_eff     (bh_eff),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

endmodule
`default_nettype wire
